@@ hdl/nntc_pkg.sv @@
// shared constants and types for the nearest-neighbour tour cost unit
package nntc_pkg;

	localparam int MAX_CITIES = 1024;
	localparam int COORD_BITS = 20;
	localparam int IDX_BITS   = $clog2(MAX_CITIES);
	localparam int CNT_BITS   = IDX_BITS + 1;
	localparam int D_BITS     = 2 * COORD_BITS + 1;
	localparam int ROOT_BITS  = (D_BITS + 1) / 2;
	localparam int PROD_BITS  = 2 * ROOT_BITS;
	localparam int CMP_BITS   = PROD_BITS + 4;
	localparam int BIT_BITS   = $clog2(ROOT_BITS);
	localparam int LEN_BITS   = ROOT_BITS;
	localparam int COST_BITS  = 31;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// request to the edge length unit
	typedef struct packed {
		logic   start;
		logic   att;
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
	} len_req_t;

	typedef struct packed {
		logic                done;
		logic [LEN_BITS-1:0] len;
	} len_rsp_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_SQX,
		L_SQY,
		L_SUM,
		L_MUL,
		L_CMP,
		L_FIN
	} len_state_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_MARK0,
		ST_CUR,
		ST_RD,
		ST_CHK,
		ST_LEN,
		ST_STEP,
		ST_CLOSE,
		ST_CLOSEW,
		ST_PUB
	} state_t;

endpackage

@@ hdl/nntc_city_if.sv @@
// handshake channel carrying one city item
interface nntc_city_if;
	import nntc_pkg::*;

	logic   valid;
	logic   ready;
	coord_t coord_x;
	coord_t coord_y;
	logic   last_city;

	modport source (output valid, output coord_x, output coord_y, output last_city,
		input ready);
	modport sink (input valid, input coord_x, input coord_y, input last_city,
		output ready);
endinterface

@@ hdl/nntc_result_if.sv @@
// handshake channel carrying one tour result item
interface nntc_result_if;
	import nntc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [COST_BITS-1:0] tour_cost;
	logic                 cities_dropped;

	modport source (output valid, output tour_cost, output cities_dropped, input ready);
	modport sink (input valid, input tour_cost, input cities_dropped, output ready);
endinterface

@@ hdl/nntc_len.sv @@
// edge length unit: squares on one shared multiplier, then a bitwise root search
module nntc_len (
	input  logic             clk,
	input  logic             arst_n,
	input  nntc_pkg::len_req_t req,
	output nntc_pkg::len_rsp_t rsp
);
	import nntc_pkg::*;

	len_state_t st_q, st_d;

	logic [ROOT_BITS-1:0] dx_q, dy_q;
	logic                 att_q;
	logic [PROD_BITS-1:0] prod_q;
	logic [PROD_BITS-1:0] dsq_q;
	logic [D_BITS-1:0]    d_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [PROD_BITS-1:0] rsq_q;
	logic [BIT_BITS-1:0]  bit_q;
	logic [LEN_BITS-1:0]  len_q;
	logic                 done_q;

	logic [ROOT_BITS-1:0] mul_a;
	logic [ROOT_BITS-1:0] cand;
	logic [CMP_BITS-1:0]  prod_ext;
	logic [CMP_BITS-1:0]  scaled;
	logic                 take;
	logic                 round_up;
	logic signed [COORD_BITS:0] ddx, ddy;
	logic [COORD_BITS:0]  mx, my;

	assign ddx = {req.ax[COORD_BITS-1], req.ax} - {req.bx[COORD_BITS-1], req.bx};
	assign ddy = {req.ay[COORD_BITS-1], req.ay} - {req.by[COORD_BITS-1], req.by};
	assign mx  = ddx[COORD_BITS] ? (COORD_BITS+1)'(-ddx) : ddx;
	assign my  = ddy[COORD_BITS] ? (COORD_BITS+1)'(-ddy) : ddy;

	assign cand     = root_q | (ROOT_BITS'(1) << bit_q);
	assign prod_ext = CMP_BITS'(prod_q);
	assign scaled   = att_q ? ((prod_ext << 3) + (prod_ext << 1)) : prod_ext;
	// euclid keeps r*r <= d, att keeps 10*t*t < d
	assign take     = att_q ? (scaled < CMP_BITS'(d_q)) : (scaled <= CMP_BITS'(d_q));
	assign round_up = (PROD_BITS+1)'(d_q) > ((PROD_BITS+1)'(rsq_q) + (PROD_BITS+1)'(root_q));

	always_comb begin
		unique case (st_q)
			L_SQX:   mul_a = dx_q;
			L_SQY:   mul_a = dy_q;
			default: mul_a = cand;
		endcase
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			L_IDLE: if (req.start) st_d = L_SQX;
			L_SQX:  st_d = L_SQY;
			L_SQY:  st_d = L_SUM;
			L_SUM:  st_d = L_MUL;
			L_MUL:  st_d = L_CMP;
			L_CMP:  st_d = (bit_q == '0) ? L_FIN : L_MUL;
			L_FIN:  st_d = L_IDLE;
			default: st_d = L_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == L_FIN);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(mul_a);
		unique case (st_q)
			L_IDLE: begin
				dx_q  <= ROOT_BITS'(mx);
				dy_q  <= ROOT_BITS'(my);
				att_q <= req.att;
			end
			L_SQY: dsq_q <= prod_q;
			L_SUM: begin
				d_q    <= D_BITS'(dsq_q + prod_q);
				root_q <= '0;
				rsq_q  <= '0;
				bit_q  <= BIT_BITS'(ROOT_BITS - 1);
			end
			L_CMP: begin
				if (take) begin
					root_q <= cand;
					rsq_q  <= prod_q;
				end
				bit_q <= bit_q - 1'b1;
			end
			L_FIN: begin
				if (att_q)
					len_q <= (d_q == '0) ? '0 : root_q + 1'b1;
				else
					len_q <= root_q + LEN_BITS'(round_up);
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.len  = len_q;
endmodule

@@ hdl/nearest_neighbor_tour_cost_unit.sv @@
// top level: city store, visited map and the tour sequencer
// Cities enter on city_in, one item per cycle while the unit is loading; each
// is written to the next free store entry, and cities beyond 1024 are dropped
// and flagged. An item with last_city set ends the set and starts the tour;
// city_in.ready stays low until the tour result is registered.
// The tour begins with a sweep clearing the visited map. Each tour
// step scans every stored city: a skipped entry needs no length, and an
// evaluated one waits on the single shared multiplier of the edge length
// unit (two squares, then 21 square-and-compare rounds of its root search).
// One result item per set appears on result_out and is held in an output
// register until taken; loading of the next set goes on meanwhile, and only
// the end of the next tour waits for a stalled receiver.
// cfg_we with cfg_wdata selects the metric: 0 rounded Euclidean, 1 ATT.
// Reset (arst_n low) empties the store, clears the flag and the metric.
module nearest_neighbor_tour_cost_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	nntc_city_if.sink            city_in,
	nntc_result_if.source        result_out,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);
	import nntc_pkg::*;

	state_t st_q, st_d;

	coord_t x_mem [MAX_CITIES];
	coord_t y_mem [MAX_CITIES];
	logic   vis_mem [MAX_CITIES];

	coord_t rd_x_q, rd_y_q;
	logic   rd_vis_q;
	coord_t cur_x_q, cur_y_q, org_x_q, org_y_q;

	logic                 att_q;
	logic [CNT_BITS-1:0]  count_q;
	logic                 ovf_q;
	logic [IDX_BITS-1:0]  clr_q;
	logic [IDX_BITS-1:0]  scan_q;
	logic [IDX_BITS-1:0]  cur_idx_q;
	logic [IDX_BITS-1:0]  best_idx_q;
	logic [LEN_BITS-1:0]  best_len_q;
	logic                 found_q;
	logic [CNT_BITS-1:0]  seen_q;
	logic [COST_BITS-1:0] cost_q;
	logic                 out_valid_q;
	logic [COST_BITS-1:0] out_cost_q;
	logic                 out_drop_q;

	logic                 accept;
	logic                 store_we;
	logic                 vis_we;
	logic                 vis_wd;
	logic [IDX_BITS-1:0]  vis_idx;
	logic [IDX_BITS-1:0]  rd_idx;
	logic                 skip;
	logic                 scan_end;
	logic                 better;
	logic [LEN_BITS-1:0]  add_len;
	logic [COST_BITS:0]   cost_sum;
	logic [COST_BITS-1:0] cost_sat;
	len_req_t             req;
	len_rsp_t             rsp;

	assign city_in.ready = (st_q == ST_LOAD);
	assign accept        = city_in.valid && city_in.ready;
	assign store_we      = accept && (count_q < CNT_BITS'(MAX_CITIES));

	assign skip     = rd_vis_q || (scan_q == cur_idx_q);
	assign scan_end = ({1'b0, scan_q} == count_q - 1'b1);
	assign better   = !found_q || (rsp.len < best_len_q);

	assign add_len  = (st_q == ST_STEP) ? best_len_q : rsp.len;
	assign cost_sum = {1'b0, cost_q} + (COST_BITS+1)'(add_len);
	assign cost_sat = cost_sum[COST_BITS] ? '1 : cost_sum[COST_BITS-1:0];

	assign req.start = ((st_q == ST_CHK) && !skip) || (st_q == ST_CLOSE);
	assign req.att   = att_q;
	assign req.ax    = cur_x_q;
	assign req.ay    = cur_y_q;
	assign req.bx    = (st_q == ST_CLOSE) ? org_x_q : rd_x_q;
	assign req.by    = (st_q == ST_CLOSE) ? org_y_q : rd_y_q;

	nntc_len u_len (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		st_d    = st_q;
		vis_we  = 1'b0;
		vis_wd  = 1'b0;
		vis_idx = clr_q;
		rd_idx  = scan_q;
		unique case (st_q)
			ST_LOAD: if (accept && city_in.last_city) st_d = ST_CLEAR;
			ST_CLEAR: begin
				vis_we = 1'b1;
				if (clr_q == IDX_BITS'(MAX_CITIES - 1)) st_d = ST_MARK0;
			end
			ST_MARK0: begin
				vis_we  = 1'b1;
				vis_wd  = 1'b1;
				vis_idx = '0;
				rd_idx  = '0;
				st_d    = ST_CUR;
			end
			ST_CUR: st_d = (seen_q < count_q) ? ST_RD : ST_CLOSE;
			ST_RD: st_d = ST_CHK;
			ST_CHK: begin
				if (!skip)         st_d = ST_LEN;
				else if (scan_end) st_d = ST_STEP;
				else               st_d = ST_RD;
			end
			ST_LEN: if (rsp.done) st_d = scan_end ? ST_STEP : ST_RD;
			ST_STEP: begin
				vis_we  = 1'b1;
				vis_wd  = 1'b1;
				vis_idx = best_idx_q;
				rd_idx  = best_idx_q;
				st_d    = ST_CUR;
			end
			ST_CLOSE: st_d = ST_CLOSEW;
			ST_CLOSEW: if (rsp.done) st_d = ST_PUB;
			ST_PUB: if (!out_valid_q || result_out.ready) st_d = ST_LOAD;
			default: st_d = ST_LOAD;
		endcase
	end

	// store and visited map, registered read
	always_ff @(posedge clk) begin
		if (store_we) begin
			x_mem[count_q[IDX_BITS-1:0]] <= city_in.coord_x;
			y_mem[count_q[IDX_BITS-1:0]] <= city_in.coord_y;
		end
		if (vis_we) vis_mem[vis_idx] <= vis_wd;
		rd_x_q   <= x_mem[rd_idx];
		rd_y_q   <= y_mem[rd_idx];
		rd_vis_q <= vis_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_LOAD;
			att_q       <= 1'b0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			clr_q       <= '0;
			seen_q      <= '0;
			found_q     <= 1'b0;
			cost_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) att_q <= cfg_wdata;
			if (result_out.valid && result_out.ready && (st_q != ST_PUB))
				out_valid_q <= 1'b0;
			unique case (st_q)
				ST_LOAD: begin
					if (store_we) count_q <= count_q + 1'b1;
					else if (accept) ovf_q <= 1'b1;
					clr_q <= '0;
				end
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_MARK0: begin
					seen_q <= CNT_BITS'(1);
					cost_q <= '0;
				end
				ST_CUR: found_q <= 1'b0;
				ST_CHK: if (skip && !scan_end) found_q <= found_q;
				ST_LEN: if (rsp.done && better) found_q <= 1'b1;
				ST_STEP: begin
					cost_q <= cost_sat;
					seen_q <= seen_q + 1'b1;
				end
				ST_CLOSEW: if (rsp.done) cost_q <= cost_sat;
				ST_PUB: begin
					if (!out_valid_q || result_out.ready) begin
						out_valid_q <= 1'b1;
						count_q     <= '0;
						ovf_q       <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_MARK0: cur_idx_q <= '0;
			ST_CUR: begin
				cur_x_q <= rd_x_q;
				cur_y_q <= rd_y_q;
				if (seen_q == CNT_BITS'(1)) begin
					org_x_q <= rd_x_q;
					org_y_q <= rd_y_q;
				end
				scan_q <= '0;
			end
			ST_CHK: if (skip && !scan_end) scan_q <= scan_q + 1'b1;
			ST_LEN: begin
				if (rsp.done) begin
					if (better) begin
						best_len_q <= rsp.len;
						best_idx_q <= scan_q;
					end
					if (!scan_end) scan_q <= scan_q + 1'b1;
				end
			end
			ST_STEP: cur_idx_q <= best_idx_q;
			ST_PUB: begin
				if (!out_valid_q || result_out.ready) begin
					out_cost_q <= cost_q;
					out_drop_q <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.tour_cost      = out_cost_q;
	assign result_out.cities_dropped = out_drop_q;
endmodule

@@ bench/testbench.sv @@
// self-checking bench for the nearest-neighbour tour cost unit
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import nntc_pkg::*;

	localparam longint unsigned COST_CAP  = 64'h7FFF_FFFF;
	localparam longint          LIMIT     = 100_000_000;
	localparam int              LONG_HOLD = 20000;
	localparam bit              METRIC_EUCLID = 1'b0;
	localparam bit              METRIC_ATT    = 1'b1;

	typedef struct {
		coord_t x;
		coord_t y;
		bit     last;
	} city_t;

	typedef struct {
		logic [COST_BITS-1:0] cost;
		bit                   dropped;
	} tour_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	nntc_city_if   city_in ();
	nntc_result_if result_out ();

	nearest_neighbor_tour_cost_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.city_in    (city_in),
		.result_out (result_out),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	city_t  cities_to_send[$];
	tour_t  expected_tours[$];
	longint store_x[MAX_CITIES];
	longint store_y[MAX_CITIES];
	int     stored_count;
	bit     store_overflow;
	bit     att_sel;
	int     errors;
	longint cycles;
	bit     steady;
	int     hold_req;
	int     hold_done;
	int     hold_left;
	int     send_gap;
	int     recv_gap;
	bit     city_taken;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic longint unsigned edge_len(int a, int b);
		longint          dx;
		longint          dy;
		longint unsigned d;
		longint unsigned q;
		longint unsigned r;
		dx = store_x[a] - store_x[b];
		dy = store_y[a] - store_y[b];
		d = dx * dx + dy * dy;
		if (att_sel == METRIC_ATT) begin
			q = (d + 9) / 10;
			r = isqrt(q);
			if (r * r < q)
				r++;
		end else begin
			r = isqrt(d);
			if (d - r * r > r)
				r++;
		end
		return r;
	endfunction

	// greedy tour from city 0, lowest index wins a tie, closed back to city 0
	function automatic longint unsigned greedy_tour_cost();
		bit              seen[MAX_CITIES];
		int              cur;
		int              pick;
		longint unsigned best;
		longint unsigned len;
		longint unsigned sum;
		bit              found;
		sum = 0;
		cur = 0;
		for (int i = 0; i < MAX_CITIES; i++)
			seen[i] = 1'b0;
		if (stored_count == 0)
			return 0;
		seen[0] = 1'b1;
		for (int s = 1; s < stored_count; s++) begin
			found = 1'b0;
			best = 0;
			pick = 0;
			for (int i = 0; i < stored_count; i++) begin
				if (!seen[i] && i != cur) begin
					len = edge_len(cur, i);
					if (!found || len < best) begin
						found = 1'b1;
						best = len;
						pick = i;
					end
				end
			end
			sum += best;
			if (sum > COST_CAP)
				sum = COST_CAP;
			cur = pick;
			seen[cur] = 1'b1;
		end
		sum += edge_len(cur, 0);
		if (sum > COST_CAP)
			sum = COST_CAP;
		return sum;
	endfunction

	// accepted city: store it, and on the last one of a set predict the tour
	task automatic absorb_city(city_t c);
		tour_t t;
		if (stored_count < MAX_CITIES) begin
			store_x[stored_count] = longint'(c.x);
			store_y[stored_count] = longint'(c.y);
			stored_count++;
		end else begin
			store_overflow = 1'b1;
		end
		if (c.last) begin
			t.cost = greedy_tour_cost();
			t.dropped = store_overflow;
			expected_tours.push_back(t);
			stored_count = 0;
			store_overflow = 1'b0;
		end
	endtask

	// handshake sampling, checking and the run limit
	always @(posedge clk) begin
		tour_t t;
		if (arst_n) begin
			cycles++;
			if ($urandom_range(0, 299) == 0)
				steady = ~steady;
			if (cycles > LIMIT) begin
				$display("simulation failed");
				$finish;
			end
			if (city_in.valid && city_in.ready) begin
				absorb_city(cities_to_send.pop_front());
				city_taken = 1'b1;
			end
			if (result_out.valid && result_out.ready) begin
				if (expected_tours.size() == 0) begin
					errors++;
					$display("%0t: unexpected result cost %0d dropped %0b", $time,
						result_out.tour_cost, result_out.cities_dropped);
				end else begin
					t = expected_tours.pop_front();
					if (result_out.tour_cost !== t.cost) begin
						errors++;
						$display("%0t: tour_cost expected %0d actual %0d", $time,
							t.cost, result_out.tour_cost);
					end
					if (result_out.cities_dropped !== t.dropped) begin
						errors++;
						$display("%0t: cities_dropped expected %0b actual %0b", $time,
							t.dropped, result_out.cities_dropped);
					end
				end
			end
		end
	end

	// city driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!city_in.valid || city_taken) begin
				city_taken = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
					city_in.valid <= 1'b0;
				end else if (cities_to_send.size() > 0) begin
					city_in.valid <= 1'b1;
					city_in.coord_x <= cities_to_send[0].x;
					city_in.coord_y <= cities_to_send[0].y;
					city_in.last_city <= cities_to_send[0].last;
					send_gap = next_gap();
				end else begin
					city_in.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver, with the occasional long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_done != hold_req) begin
				hold_left = LONG_HOLD;
				hold_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_out.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_out.ready <= 1'b0;
			end else begin
				result_out.ready <= 1'b1;
				recv_gap = next_gap();
			end
		end
	end

	task automatic add_city(int x, int y, bit last);
		city_t c;
		c.x = coord_t'(x);
		c.y = coord_t'(y);
		c.last = last;
		cities_to_send.push_back(c);
	endtask

	task automatic drain();
		while (cities_to_send.size() > 0 || expected_tours.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_metric(bit v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		att_sel = v;
	endtask

	task automatic directed_sets();
		// lone city at the corner of the range
		add_city(-524288, 524287, 1);
		// two opposite corners, the longest possible edge
		add_city(-524288, -524288, 0);
		add_city(524287, 524287, 1);
		// all neighbours equally far: lowest index must win
		add_city(0, 0, 0);
		add_city(5, 0, 0);
		add_city(-5, 0, 0);
		add_city(0, 5, 0);
		add_city(3, 4, 1);
		add_city(1, 1, 0);
		add_city(2, 2, 0);
		add_city(0, 1, 0);
		add_city(1, 0, 0);
		add_city(-1, -1, 1);
	endtask

	task automatic random_set();
		int n;
		int r;
		int mode;
		int x;
		int y;
		r = $urandom_range(0, 99);
		if (r < 70)
			n = $urandom_range(1, 6);
		else if (r < 95)
			n = $urandom_range(7, 14);
		else
			n = $urandom_range(15, 40);
		mode = $urandom_range(0, 2);
		for (int i = 0; i < n; i++) begin
			if (mode == 0) begin
				x = $signed(coord_t'($urandom));
				y = $signed(coord_t'($urandom));
			end else if (mode == 1) begin
				// tight grid, plenty of ties
				x = $urandom_range(0, 12) - 6;
				y = $urandom_range(0, 12) - 6;
			end else begin
				x = ($urandom_range(0, 1) ? 524287 : -524288) + $urandom_range(0, 20)
					* ($urandom_range(0, 1) ? 1 : -1);
				y = $signed(coord_t'($urandom));
				x = $signed(coord_t'(x));
			end
			add_city(x, y, i == n - 1);
		end
	endtask

	initial begin
		int sent;
		int queued;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		city_in.valid = 1'b0;
		city_in.coord_x = '0;
		city_in.coord_y = '0;
		city_in.last_city = 1'b0;
		result_out.ready = 1'b0;
		errors = 0;
		cycles = 0;
		steady = 1'b0;
		hold_req = 0;
		hold_done = 0;
		hold_left = 0;
		send_gap = 0;
		recv_gap = 0;
		city_taken = 1'b0;
		stored_count = 0;
		store_overflow = 1'b0;
		att_sel = METRIC_EUCLID;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		set_metric(METRIC_EUCLID);
		directed_sets();
		drain();
		set_metric(METRIC_ATT);
		directed_sets();
		drain();

		for (int p = 0; p < 6; p++) begin
			set_metric(p[0]);
			if (p == 2)
				hold_req++;
			sent = 0;
			while (sent < 93) begin
				queued = cities_to_send.size();
				random_set();
				sent += cities_to_send.size() - queued;
				while (cities_to_send.size() > 8)
					@(posedge clk);
			end
			drain();
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
